### src/ncc_pkg.sv
// Shared types and constants for the nearest centroid classifier.
package ncc_pkg;

    localparam int DEF_MAX_CLUSTERS = 16;
    localparam int DEF_MAX_DIMS     = 16;

    localparam int CFG_W   = 5;
    localparam int COORD_W = 16;
    localparam int SQ_W    = 32;
    localparam int DIST_W  = 38;
    localparam int COUNT_W = 32;

    localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    localparam logic CFG_NUM_CLUSTERS = 1'b0;
    localparam logic CFG_NUM_DIMS     = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_CLASS = 2'd1,
        KIND_COUNT = 2'd2
    } kind_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  accept;
        logic  cent_we;
        logic  samp_we;
        logic  issue;
        logic  issue_first;
        logic  issue_last;
        logic  cnt_rd;
        logic  cnt_sel_best;
        logic  cnt_upd;
        logic  cnt_clear;
        logic  out_load;
        kind_t out_kind;
    } cmd_t;

endpackage

### src/ncc_dpath.sv
// Datapath: centroid store, sample buffer, distance pipeline, count store, result register.
module ncc_dpath #(
    parameter int MAX_CLUSTERS = ncc_pkg::DEF_MAX_CLUSTERS,
    parameter int MAX_DIMS     = ncc_pkg::DEF_MAX_DIMS,
    localparam int KW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int CENT_DEPTH = MAX_CLUSTERS * MAX_DIMS,
    localparam int AW = (CENT_DEPTH > 1) ? $clog2(CENT_DEPTH) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ncc_pkg::cmd_t                     cmd,
    input  logic [KW-1:0]                     walk_k,
    input  logic [DW-1:0]                     walk_d,
    input  logic [3:0]                        in_cluster,
    input  logic [3:0]                        in_dim,
    input  logic [ncc_pkg::COORD_W-1:0]       in_coord,
    output logic                              pipe_busy,
    output ncc_pkg::kind_t                    out_kind,
    output logic [3:0]                        out_cluster,
    output logic [ncc_pkg::DIST_W-1:0]        out_dist,
    output logic [ncc_pkg::COUNT_W-1:0]       out_count
);

    logic [ncc_pkg::COORD_W-1:0] cent_mem [CENT_DEPTH];
    logic [ncc_pkg::COORD_W-1:0] samp_mem [MAX_DIMS];
    logic [ncc_pkg::COUNT_W-1:0] cnt_mem  [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0]     cnt_vld_reg;

    logic [AW-1:0] cent_waddr;
    logic [AW-1:0] cent_raddr;
    logic          cent_in_range;
    logic          samp_in_range;
    logic          ci_in_range;

    // stage 1: operands read
    logic                        p1_valid_reg;
    logic                        p1_first_reg;
    logic                        p1_last_reg;
    logic [KW-1:0]               p1_k_reg;
    logic [ncc_pkg::COORD_W-1:0] cent_q_reg;
    logic [ncc_pkg::COORD_W-1:0] samp_q_reg;

    // stage 2: square
    logic                        p2_valid_reg;
    logic                        p2_first_reg;
    logic                        p2_last_reg;
    logic [KW-1:0]               p2_k_reg;
    logic [ncc_pkg::SQ_W-1:0]    sq_reg;
    logic signed [ncc_pkg::COORD_W:0] diff;
    logic [ncc_pkg::COORD_W:0]   mag;

    // stage 3: accumulate and compare
    logic [ncc_pkg::DIST_W-1:0]  acc_reg;
    logic [ncc_pkg::DIST_W-1:0]  acc_base;
    logic [ncc_pkg::DIST_W:0]    acc_sum;
    logic [ncc_pkg::DIST_W-1:0]  acc_sat;
    logic [ncc_pkg::DIST_W-1:0]  best_dist_reg;
    logic [KW-1:0]               best_k_reg;

    // count path
    logic [KW-1:0]               cnt_raddr;
    logic [ncc_pkg::COUNT_W-1:0] cnt_q_reg;
    logic                        cnt_qv_reg;
    logic [ncc_pkg::COUNT_W-1:0] cnt_val;
    logic [ncc_pkg::COUNT_W-1:0] cnt_new;
    logic [3:0]                  ci_reg;

    logic [3:0]                  out_cluster_reg;
    logic [ncc_pkg::DIST_W-1:0]  out_dist_reg;
    logic [ncc_pkg::COUNT_W-1:0] out_count_reg;
    ncc_pkg::kind_t              out_kind_reg;

    assign cent_in_range = (int'(in_cluster) < MAX_CLUSTERS) && (int'(in_dim) < MAX_DIMS);
    assign samp_in_range = int'(in_dim) < MAX_DIMS;
    assign ci_in_range   = int'(in_cluster) < MAX_CLUSTERS;
    assign cent_waddr    = AW'(int'(in_cluster) * MAX_DIMS + int'(in_dim));
    assign cent_raddr    = AW'(int'(walk_k) * MAX_DIMS + int'(walk_d));

    // Centroid and sample stores, registered read
    always_ff @(posedge aclk) begin
        if (cmd.cent_we && cent_in_range) begin
            cent_mem[cent_waddr] <= in_coord;
        end
        if (cmd.samp_we && samp_in_range) begin
            samp_mem[DW'(in_dim)] <= in_coord;
        end
        cent_q_reg <= cent_mem[cent_raddr];
        samp_q_reg <= samp_mem[walk_d];
    end

    assign diff = $signed({samp_q_reg[ncc_pkg::COORD_W-1], samp_q_reg})
                - $signed({cent_q_reg[ncc_pkg::COORD_W-1], cent_q_reg});
    assign mag  = diff[ncc_pkg::COORD_W] ? (ncc_pkg::COORD_W+1)'(-diff)
                                         : (ncc_pkg::COORD_W+1)'(diff);

    // Clamp as the sum grows; the sum only rises, so the end result matches
    assign acc_base = p2_first_reg ? '0 : acc_reg;
    assign acc_sum  = {1'b0, acc_base} + (ncc_pkg::DIST_W+1)'(sq_reg);
    assign acc_sat  = (acc_sum > {1'b0, ncc_pkg::DIST_MAX}) ? ncc_pkg::DIST_MAX
                                                           : acc_sum[ncc_pkg::DIST_W-1:0];

    always_ff @(posedge aclk) begin
        p1_first_reg <= cmd.issue_first;
        p1_last_reg  <= cmd.issue_last;
        p1_k_reg     <= walk_k;
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
        p2_k_reg     <= p1_k_reg;
        sq_reg       <= ncc_pkg::SQ_W'(mag[ncc_pkg::COORD_W-1:0])
                      * ncc_pkg::SQ_W'(mag[ncc_pkg::COORD_W-1:0]);
        if (p2_valid_reg) begin
            acc_reg <= acc_sat;
            if (p2_last_reg && ((p2_k_reg == '0) || (acc_sat < best_dist_reg))) begin
                best_dist_reg <= acc_sat;
                best_k_reg    <= p2_k_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= cmd.issue;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    assign pipe_busy = p1_valid_reg | p2_valid_reg;

    // Count store: one read address, registered read, valid bits stand for the zero state
    assign cnt_raddr = cmd.cnt_sel_best ? best_k_reg : KW'(in_cluster);
    assign cnt_val   = cnt_qv_reg ? cnt_q_reg : '0;
    assign cnt_new   = (cnt_val == ncc_pkg::COUNT_MAX) ? cnt_val : cnt_val + 1'b1;

    always_ff @(posedge aclk) begin
        if (cmd.cnt_rd) begin
            cnt_q_reg <= cnt_mem[cnt_raddr];
        end
        if (cmd.cnt_upd) begin
            cnt_mem[best_k_reg] <= cnt_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg <= '0;
            cnt_qv_reg  <= 1'b0;
        end else begin
            if (cmd.cnt_rd) begin
                cnt_qv_reg <= cnt_vld_reg[cnt_raddr] && (cmd.cnt_sel_best || ci_in_range);
            end
            if (cmd.cnt_clear) begin
                cnt_vld_reg <= '0;
            end else if (cmd.cnt_upd) begin
                cnt_vld_reg[best_k_reg] <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ci_reg <= in_cluster;
        end
        if (cmd.out_load) begin
            out_kind_reg <= cmd.out_kind;
            unique case (cmd.out_kind)
                ncc_pkg::KIND_CLASS: begin
                    out_cluster_reg <= 4'(best_k_reg);
                    out_dist_reg    <= best_dist_reg;
                    out_count_reg   <= cnt_new;
                end
                ncc_pkg::KIND_COUNT: begin
                    out_cluster_reg <= ci_reg;
                    out_dist_reg    <= '0;
                    out_count_reg   <= cnt_val;
                end
                default: begin
                    out_cluster_reg <= '0;
                    out_dist_reg    <= '0;
                    out_count_reg   <= '0;
                end
            endcase
        end
    end

    assign out_kind    = out_kind_reg;
    assign out_cluster = out_cluster_reg;
    assign out_dist    = out_dist_reg;
    assign out_count   = out_count_reg;

endmodule

### src/ncc_ctrl.sv
// Controller: configuration registers, handshakes and the centroid walk sequencer.
module ncc_ctrl #(
    parameter int MAX_CLUSTERS = ncc_pkg::DEF_MAX_CLUSTERS,
    parameter int MAX_DIMS     = ncc_pkg::DEF_MAX_DIMS,
    localparam int KW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [ncc_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [1:0]                 in_action,
    input  logic [3:0]                 in_dim,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic                       pipe_busy,
    output ncc_pkg::cmd_t              cmd,
    output logic [KW-1:0]              walk_k,
    output logic [DW-1:0]              walk_d
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_CUPD,
        ST_CREPLY
    } state_t;

    state_t                     state_reg, state_next;
    logic [KW-1:0]              k_reg, k_next;
    logic [DW-1:0]              d_reg, d_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [ncc_pkg::CFG_W-1:0]  num_clusters_reg;
    logic [ncc_pkg::CFG_W-1:0]  num_dims_reg;
    logic [KW-1:0]              nk_last;
    logic [DW-1:0]              nd_last;
    logic                       accept;
    logic                       classify;
    ncc_pkg::action_t           action;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_clusters_reg <= ncc_pkg::CFG_W'(1);
            num_dims_reg     <= ncc_pkg::CFG_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                ncc_pkg::CFG_NUM_CLUSTERS: num_clusters_reg <= cfg_wdata;
                ncc_pkg::CFG_NUM_DIMS:     num_dims_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Zero counts as one; clip at the store size
    always_comb begin
        if (num_clusters_reg == '0) begin
            nk_last = '0;
        end else if (int'(num_clusters_reg) > MAX_CLUSTERS) begin
            nk_last = KW'(MAX_CLUSTERS - 1);
        end else begin
            nk_last = KW'(num_clusters_reg - 1'b1);
        end
        if (num_dims_reg == '0) begin
            nd_last = '0;
        end else if (int'(num_dims_reg) > MAX_DIMS) begin
            nd_last = DW'(MAX_DIMS - 1);
        end else begin
            nd_last = DW'(num_dims_reg - 1'b1);
        end
    end

    assign action   = ncc_pkg::action_t'(in_action);
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign classify = (action == ncc_pkg::ACT_SAMPLE) && (int'(in_dim) == int'(nd_last));

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        d_next     = d_reg;
        cmd        = '0;
        cmd.out_kind = ncc_pkg::KIND_ACK;
        cmd.accept   = accept;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (action)
                        ncc_pkg::ACT_LOAD: begin
                            cmd.cent_we  = 1'b1;
                            cmd.out_load = 1'b1;
                        end
                        ncc_pkg::ACT_SAMPLE: begin
                            cmd.samp_we = 1'b1;
                            if (classify) begin
                                k_next     = '0;
                                d_next     = '0;
                                state_next = ST_WALK;
                            end else begin
                                cmd.out_load = 1'b1;
                            end
                        end
                        ncc_pkg::ACT_READ: begin
                            cmd.cnt_rd = 1'b1;
                            state_next = ST_CREPLY;
                        end
                        default: begin
                            cmd.cnt_clear = 1'b1;
                            cmd.out_load  = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                cmd.issue       = 1'b1;
                cmd.issue_first = (d_reg == '0);
                cmd.issue_last  = (d_reg == nd_last);
                if (d_reg == nd_last) begin
                    d_next = '0;
                    if (k_reg == nk_last) begin
                        state_next = ST_DRAIN;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end else begin
                    d_next = d_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    cmd.cnt_rd       = 1'b1;
                    cmd.cnt_sel_best = 1'b1;
                    state_next       = ST_CUPD;
                end
            end
            ST_CUPD: begin
                cmd.cnt_upd  = 1'b1;
                cmd.out_load = 1'b1;
                cmd.out_kind = ncc_pkg::KIND_CLASS;
                state_next   = ST_IDLE;
            end
            ST_CREPLY: begin
                cmd.out_load = 1'b1;
                cmd.out_kind = ncc_pkg::KIND_COUNT;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_tvalid_next = cmd.out_load || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            d_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            d_reg        <= d_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign walk_k   = k_reg;
    assign walk_d   = d_reg;

    // A result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending transfer");

    // The count update sees the final best cluster
    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CUPD) |-> !pipe_busy)
        else $error("count update before the distance pipeline drained");

    a_walk_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> ((k_reg <= nk_last) && (d_reg <= nd_last)))
        else $error("walk counters out of range");

    a_walk_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WALK) && (state_next == ST_DRAIN)) |-> cmd.issue_last)
        else $error("walk ended before the last coordinate");

endmodule

### src/nearest_centroid_classifier_unit.sv
// Nearest centroid classifier: k-means assignment with saturating per-cluster counts.
// Loads, clears and non-final sample coordinates: the result is valid in the cycle after the handshake.
// Count read: the count is registered, then loaded into the result. Final sample coordinate: the walk
// feeds one centroid coordinate per cycle (K clusters, D dims in use), then drains before the count update.
// Reset (aresetn low, synchronous) sets both registers to 1 and zeroes all counts at once;
// centroid and sample stores hold no defined value until written.
module nearest_centroid_classifier_unit #(
    parameter int MAX_CLUSTERS = ncc_pkg::DEF_MAX_CLUSTERS,
    parameter int MAX_DIMS     = ncc_pkg::DEF_MAX_DIMS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [ncc_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,   // cluster_index[3:0], dim_index[7:4], coord_value[23:8]
    input  logic [1:0]                 s_tuser,   // action[1:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [79:0]                m_tdata,   // best_cluster[3:0], min_distance[41:4], cluster_count[73:42]
    output logic [1:0]                 m_tuser    // result_kind[1:0]
);

    localparam int KW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    ncc_pkg::cmd_t               cmd;
    logic [KW-1:0]               walk_k;
    logic [DW-1:0]               walk_d;
    logic                        pipe_busy;
    ncc_pkg::kind_t              out_kind;
    logic [3:0]                  out_cluster;
    logic [ncc_pkg::DIST_W-1:0]  out_dist;
    logic [ncc_pkg::COUNT_W-1:0] out_count;

    ncc_ctrl #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIMS     (MAX_DIMS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_action (s_tuser),
        .in_dim    (s_tdata[7:4]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .pipe_busy (pipe_busy),
        .cmd       (cmd),
        .walk_k    (walk_k),
        .walk_d    (walk_d)
    );

    ncc_dpath #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIMS     (MAX_DIMS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .walk_k      (walk_k),
        .walk_d      (walk_d),
        .in_cluster  (s_tdata[3:0]),
        .in_dim      (s_tdata[7:4]),
        .in_coord    (s_tdata[23:8]),
        .pipe_busy   (pipe_busy),
        .out_kind    (out_kind),
        .out_cluster (out_cluster),
        .out_dist    (out_dist),
        .out_count   (out_count)
    );

    assign m_tdata = {6'b0, out_count, out_dist, out_cluster};
    assign m_tuser = out_kind;

endmodule
